### rtl/kpf_pkg.sv
package kpf_pkg;

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 8;
	localparam int unsigned OUT_USER_W = 1;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned MAX_PADS   = 16;

	// register indexes on the configuration channel
	localparam logic [2:0] REG_PAD_COUNT   = 3'd0;
	localparam logic [2:0] REG_PAD_CHAR    = 3'd1;
	localparam logic [2:0] REG_START_CHAR  = 3'd2;
	localparam logic [2:0] REG_EOL_CHAR    = 3'd3;
	localparam logic [2:0] REG_PARITY_MODE = 3'd4;
	localparam logic [2:0] REG_CHECK_TYPE  = 3'd5;

	localparam logic [2:0] PAR_NONE  = 3'd0;
	localparam logic [2:0] PAR_MARK  = 3'd1;
	localparam logic [2:0] PAR_SPACE = 3'd2;
	localparam logic [2:0] PAR_ODD   = 3'd3;
	localparam logic [2:0] PAR_EVEN  = 3'd4;

	localparam logic [1:0] CHK_UNSET = 2'd0;
	localparam logic [1:0] CHK_SUM6  = 2'd1;
	localparam logic [1:0] CHK_SUM12 = 2'd2;
	localparam logic [1:0] CHK_CRC   = 2'd3;

	localparam logic [7:0] CHAR_BIAS = 8'd32;

	typedef struct packed {
		logic [4:0] pad_count;
		logic [7:0] pad_char;
		logic [7:0] start_char;
		logic [7:0] eol_char;
		logic [2:0] parity_mode;
		logic [1:0] check_type;
	} cfg_t;

	typedef struct packed {
		logic [6:0] pkt_kind;
		logic [5:0] seq_num;
		logic [6:0] data_len;
		logic [7:0] data_byte;
		logic       has_byte;
		logic       first;
		logic       last;
	} item_t;

	function automatic logic [7:0] kpf_parity(input logic [7:0] c, input logic [2:0] mode);
		logic p;
		p = ^c[6:0];
		case (mode)
			PAR_MARK:  return {1'b1, c[6:0]};
			PAR_SPACE: return {1'b0, c[6:0]};
			PAR_ODD:   return {~p, c[6:0]};
			PAR_EVEN:  return {p, c[6:0]};
			default:   return c;
		endcase
	endfunction

	// one nibble step, factor 010201 octal
	function automatic logic [15:0] kpf_crc_nib(input logic [15:0] crc, input logic [3:0] nib);
		logic [3:0] q;
		q = crc[3:0] ^ nib;
		return (crc >> 4) ^ {q, 1'b0, q, 3'b000, q};
	endfunction

	function automatic logic [15:0] kpf_crc_byte(input logic [15:0] crc, input logic [7:0] v);
		logic [15:0] c1;
		c1 = kpf_crc_nib(crc, v[3:0]);
		return kpf_crc_nib(c1, v[7:4]);
	endfunction

endpackage

### rtl/kermit_packet_framer_unit.sv
// channel   dir   handshake                 payload
// s_axis    in    s_axis_tvalid/tready      tdata: kind, seq, len, byte; tuser: has, first; tlast
// m_axis    out   m_axis_tvalid/tready      tdata: line byte; tuser: eol flag; tlast: end of run
// cfg       in    cfg_valid/cfg_ready       cfg_addr: register index; cfg_data: value
//
// One line byte per cycle from the back sequencer through the output register, while a word is
// queued and m_axis_tready does not stall the output. The bytes a word yields: pads + 4 for first,
// 1 for a data byte, check chars + pads + 1 for last; a word with no flag set is dropped with no output.
// A four-entry queue sits between front and back; each side stalls on its own.
// Reset clears configuration to defaults and both running checks to zero.
module kermit_packet_framer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// pkt_kind[6:0], seq_num[12:7], data_len[19:13], data_byte[27:20], zero fill
	input  logic [kpf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// has_byte[0], first[1]
	input  logic [kpf_pkg::IN_USER_W-1:0]  s_axis_tuser,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// out_byte[7:0]
	output logic [kpf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// packet_done[0]
	output logic [kpf_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic                           m_axis_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [2:0]                     cfg_addr,
	input  logic [7:0]                     cfg_data
);
	import kpf_pkg::*;

	cfg_t  cfg_q;
	item_t head;
	logic  head_valid;
	logic  pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pad_count   <= '0;
			cfg_q.pad_char    <= '0;
			cfg_q.start_char  <= 8'd1;
			cfg_q.eol_char    <= 8'd13;
			cfg_q.parity_mode <= PAR_NONE;
			cfg_q.check_type  <= CHK_SUM6;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_PAD_COUNT:   cfg_q.pad_count   <= cfg_data[4:0];
				REG_PAD_CHAR:    cfg_q.pad_char    <= cfg_data;
				REG_START_CHAR:  cfg_q.start_char  <= cfg_data;
				REG_EOL_CHAR:    cfg_q.eol_char    <= cfg_data;
				REG_PARITY_MODE: cfg_q.parity_mode <= cfg_data[2:0];
				REG_CHECK_TYPE:  cfg_q.check_type  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	kpf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop)
	);

	kpf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

`ifndef SYNTHESIS
	a_eol_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("eol word without end of run");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready && !pop |=> !s_axis_tready)
		else $error("queue space appeared without a pop");
`endif

endmodule

### rtl/kpf_front.sv
module kpf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// pkt_kind[6:0], seq_num[12:7], data_len[19:13], data_byte[27:20], zero fill
	input  logic [kpf_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// has_byte[0], first[1]
	input  logic [kpf_pkg::IN_USER_W-1:0] s_axis_tuser,
	input  logic                          s_axis_tlast,
	output kpf_pkg::item_t                head,
	output logic                          head_valid,
	input  logic                          pop
);
	import kpf_pkg::*;

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   count_q;
	item_t              in_item;
	logic               push;
	logic               take;

	always_comb begin
		in_item.pkt_kind  = s_axis_tdata[6:0];
		in_item.seq_num   = s_axis_tdata[12:7];
		in_item.data_len  = s_axis_tdata[19:13];
		in_item.data_byte = s_axis_tdata[27:20];
		in_item.has_byte  = s_axis_tuser[0];
		in_item.first     = s_axis_tuser[1];
		in_item.last      = s_axis_tlast;
	end

	assign s_axis_tready = (count_q != (FIFO_AW+1)'(FIFO_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign head_valid    = (count_q != '0);
	assign take          = pop && head_valid;
	assign head          = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (take) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/kpf_back.sv
module kpf_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  kpf_pkg::cfg_t                  cfg,
	input  kpf_pkg::item_t                 head,
	input  logic                           head_valid,
	output logic                           pop,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// out_byte[7:0]
	output logic [kpf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// packet_done[0]
	output logic [kpf_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic                           m_axis_tlast
);
	import kpf_pkg::*;

	typedef enum logic [3:0] {
		PH_PAD0  = 4'd0,
		PH_START = 4'd1,
		PH_LEN   = 4'd2,
		PH_SEQ   = 4'd3,
		PH_KIND  = 4'd4,
		PH_DATA  = 4'd5,
		PH_CHK   = 4'd6,
		PH_PAD1  = 4'd7,
		PH_EOL   = 4'd8,
		PH_NONE  = 4'd9
	} phase_t;

	localparam int unsigned NPH = 9;

	phase_t      ph_q;
	logic        busy_q;
	logic [3:0]  cnt_q;
	logic [15:0] sum_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic        out_done_q;

	logic [4:0]     pads;
	logic [1:0]     ct;
	logic [NPH-1:0] app;
	phase_t         fst;
	phase_t         cur_ph;
	phase_t         nxt;
	logic [3:0]     cur_cnt;
	logic [4:0]     lim;
	logic           ph_end;
	logic           out_free;
	logic           emit;
	logic           run_end;
	logic [5:0]     chk6;
	logic [7:0]     raw;
	logic [7:0]     b;
	logic [7:0]     v;
	logic           par_on;
	logic           checked;

	always_comb begin
		pads = (cfg.pad_count > 5'(MAX_PADS)) ? 5'(MAX_PADS) : cfg.pad_count;
		ct   = (cfg.check_type == CHK_UNSET) ? CHK_SUM6 : cfg.check_type;

		app           = '0;
		app[PH_PAD0]  = head.first && (pads != '0);
		app[PH_START] = head.first;
		app[PH_LEN]   = head.first;
		app[PH_SEQ]   = head.first;
		app[PH_KIND]  = head.first;
		app[PH_DATA]  = head.has_byte;
		app[PH_CHK]   = head.last;
		app[PH_PAD1]  = head.last && (pads != '0);
		app[PH_EOL]   = head.last;

		fst = PH_NONE;
		for (int k = NPH - 1; k >= 0; k--) begin
			if (app[k]) begin
				fst = phase_t'(4'(k));
			end
		end

		cur_ph  = busy_q ? ph_q : fst;
		cur_cnt = busy_q ? cnt_q : '0;

		nxt = PH_NONE;
		for (int k = NPH - 1; k >= 0; k--) begin
			if (app[k] && (k > int'(cur_ph))) begin
				nxt = phase_t'(4'(k));
			end
		end

		case (cur_ph)
			PH_PAD0, PH_PAD1: lim = pads;
			PH_CHK:           lim = {3'b000, ct};
			default:          lim = 5'd1;
		endcase
		ph_end  = (({1'b0, cur_cnt} + 5'd1) == lim);
		run_end = ph_end && (nxt == PH_NONE);

		out_free = !out_valid_q || m_axis_tready;
		emit     = head_valid && (cur_ph != PH_NONE) && out_free;
		pop      = head_valid && ((cur_ph == PH_NONE) || (out_free && run_end));

		chk6 = sum_q[5:0];
		case (ct)
			CHK_SUM12: chk6 = (cur_cnt == 4'd0) ? sum_q[11:6] : sum_q[5:0];
			CHK_CRC: begin
				case (cur_cnt)
					4'd0:    chk6 = {2'b00, crc_q[15:12]};
					4'd1:    chk6 = crc_q[11:6];
					default: chk6 = crc_q[5:0];
				endcase
			end
			default:   chk6 = sum_q[5:0] + {4'b0000, sum_q[7:6]};
		endcase

		case (cur_ph)
			PH_PAD0, PH_PAD1: raw = cfg.pad_char;
			PH_START:         raw = cfg.start_char;
			PH_LEN:           raw = {1'b0, head.data_len} + {6'b0, ct} + 8'd2 + CHAR_BIAS;
			PH_SEQ:           raw = {2'b00, head.seq_num} + CHAR_BIAS;
			PH_KIND:          raw = {1'b0, head.pkt_kind};
			PH_DATA:          raw = head.data_byte;
			PH_CHK:           raw = {2'b00, chk6} + CHAR_BIAS;
			PH_EOL:           raw = cfg.eol_char;
			default:          raw = '0;
		endcase

		b       = kpf_parity(raw, cfg.parity_mode);
		par_on  = cfg.parity_mode inside {[PAR_MARK:PAR_EVEN]};
		v       = par_on ? {1'b0, b[6:0]} : b;
		checked = cur_ph inside {PH_LEN, PH_SEQ, PH_KIND, PH_DATA};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_NONE;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			sum_q       <= '0;
			crc_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_done_q  <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				out_byte_q <= b;
				out_last_q <= run_end;
				out_done_q <= (cur_ph == PH_EOL);
				if (ph_end) begin
					cnt_q <= '0;
					if (nxt == PH_NONE) begin
						busy_q <= 1'b0;
					end else begin
						busy_q <= 1'b1;
						ph_q   <= nxt;
					end
				end else begin
					busy_q <= 1'b1;
					ph_q   <= cur_ph;
					cnt_q  <= cur_cnt + 4'd1;
				end
				if (cur_ph == PH_LEN) begin
					sum_q <= {8'b0, v};
					crc_q <= kpf_crc_byte('0, v);
				end else if (checked) begin
					sum_q <= sum_q + {8'b0, v};
					crc_q <= kpf_crc_byte(crc_q, v);
				end
			end
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_byte_q;
	assign m_axis_tlast    = out_last_q;
	assign m_axis_tuser[0] = out_done_q;

endmodule

### dv/tb.sv
module tb;
	import kpf_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 64;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       eol;
		logic       run_end;
	} line_word_t;

	class line_scoreboard;
		logic [4:0]  pad_count;
		logic [7:0]  pad_char;
		logic [7:0]  start_char;
		logic [7:0]  eol_char;
		logic [2:0]  parity_mode;
		logic [1:0]  check_type;
		logic [15:0] byte_sum;
		logic [15:0] crc_value;
		line_word_t  line_q[$];
		int          errors;

		function new();
			pad_count   = '0;
			pad_char    = '0;
			start_char  = 8'd1;
			eol_char    = 8'd13;
			parity_mode = PAR_NONE;
			check_type  = CHK_SUM6;
			byte_sum    = '0;
			crc_value   = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] val);
			case (idx)
				REG_PAD_COUNT:   pad_count = val[4:0];
				REG_PAD_CHAR:    pad_char = val;
				REG_START_CHAR:  start_char = val;
				REG_EOL_CHAR:    eol_char = val;
				REG_PARITY_MODE: parity_mode = val[2:0];
				REG_CHECK_TYPE:  check_type = val[1:0];
				default: ;
			endcase
		endfunction

		function bit parity_active();
			return parity_mode inside {PAR_MARK, PAR_SPACE, PAR_ODD, PAR_EVEN};
		endfunction

		function logic [7:0] line_parity(logic [7:0] c);
			logic odd_ones;
			odd_ones = ($countones(c[6:0]) % 2) == 1;
			case (parity_mode)
				PAR_MARK:  return {1'b1, c[6:0]};
				PAR_SPACE: return {1'b0, c[6:0]};
				PAR_ODD:   return {!odd_ones, c[6:0]};
				PAR_EVEN:  return {odd_ones, c[6:0]};
				default:   return c;
			endcase
		endfunction

		function void crc_nibble(logic [3:0] nib);
			logic [15:0] q;
			q = {12'd0, crc_value[3:0] ^ nib};
			crc_value = (crc_value >> 4) ^ 16'(q * 16'o10201);
		endfunction

		function void emit(logic [7:0] b, logic eol);
			line_q.push_back({b, eol, 1'b0});
		endfunction

		// byte that is covered by the block check
		function void emit_counted(logic [7:0] c);
			logic [7:0] b;
			logic [7:0] v;
			b = line_parity(c);
			v = parity_active() ? {1'b0, b[6:0]} : b;
			emit(b, 1'b0);
			byte_sum = byte_sum + 16'(v);
			crc_nibble(v[3:0]);
			crc_nibble(v[7:4]);
		endfunction

		function void note_input(item_t it);
			int          queued;
			int          npads;
			logic [1:0]  chk;
			logic [5:0]  fold;
			queued = line_q.size();
			chk = (check_type == CHK_UNSET) ? CHK_SUM6 : check_type;
			npads = (pad_count > MAX_PADS) ? MAX_PADS : int'(pad_count);
			if (it.first) begin
				byte_sum  = '0;
				crc_value = '0;
				repeat (npads) emit(line_parity(pad_char), 1'b0);
				emit(line_parity(start_char), 1'b0);
				emit_counted(8'(int'(it.data_len) + int'(chk) + 2 + int'(CHAR_BIAS)));
				emit_counted({2'b00, it.seq_num} + CHAR_BIAS);
				emit_counted({1'b0, it.pkt_kind});
			end
			if (it.has_byte)
				emit_counted(it.data_byte);
			if (it.last) begin
				case (chk)
					CHK_SUM12: begin
						emit(line_parity({2'b00, byte_sum[11:6]} + CHAR_BIAS), 1'b0);
						emit(line_parity({2'b00, byte_sum[5:0]} + CHAR_BIAS), 1'b0);
					end
					CHK_CRC: begin
						emit(line_parity({4'd0, crc_value[15:12]} + CHAR_BIAS), 1'b0);
						emit(line_parity({2'b00, crc_value[11:6]} + CHAR_BIAS), 1'b0);
						emit(line_parity({2'b00, crc_value[5:0]} + CHAR_BIAS), 1'b0);
					end
					default: begin
						fold = byte_sum[5:0] + {4'd0, byte_sum[7:6]};
						emit(line_parity({2'b00, fold} + CHAR_BIAS), 1'b0);
					end
				endcase
				repeat (npads) emit(line_parity(pad_char), 1'b0);
				emit(line_parity(eol_char), 1'b1);
			end
			if (line_q.size() > queued)
				line_q[line_q.size() - 1].run_end = 1'b1;
		endfunction

		function void check_word(logic [7:0] b, logic eol, logic run_end);
			line_word_t want;
			if (line_q.size() == 0) begin
				$error("unexpected word: out_byte %02h", b);
				errors++;
				return;
			end
			want = line_q.pop_front();
			if (b !== want.line_byte) begin
				$error("out_byte: expected %02h, got %02h", want.line_byte, b);
				errors++;
			end
			if (eol !== want.eol) begin
				$error("packet_done: expected %0b, got %0b", want.eol, eol);
				errors++;
			end
			if (run_end !== want.run_end) begin
				$error("run_last: expected %0b, got %0b", want.run_end, run_end);
				errors++;
			end
		endfunction

		function int pending();
			return line_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [2:0]            cfg_addr = '0;
	logic [7:0]            cfg_data = '0;

	bit                    calm = 1'b0;
	line_scoreboard        sb;

	kermit_packet_framer_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= arst_n && (calm || $urandom_range(99) >= 33);
	end

	always @(posedge clk) begin : monitor
		item_t seen;
		if (cfg_valid && cfg_ready)
			sb.write_reg(cfg_addr, cfg_data);
		if (s_axis_tvalid && s_axis_tready) begin
			seen.pkt_kind  = s_axis_tdata[6:0];
			seen.seq_num   = s_axis_tdata[12:7];
			seen.data_len  = s_axis_tdata[19:13];
			seen.data_byte = s_axis_tdata[27:20];
			seen.has_byte  = s_axis_tuser[0];
			seen.first     = s_axis_tuser[1];
			seen.last      = s_axis_tlast;
			sb.note_input(seen);
		end
		if (m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_word(input logic [6:0] kind, input logic [5:0] seq,
			input logic [6:0] len, input logic [7:0] dbyte, input logic has,
			input logic fst, input logic lst);
		while (!calm && $urandom_range(99) < 33) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, dbyte, len, seq, kind};
		s_axis_tuser  <= {fst, has};
		s_axis_tlast  <= lst;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// hold the sender until every expected word is out, then wait a little more
	task automatic settle(input int extra);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() > 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [4:0] pads, input logic [7:0] pch,
			input logic [7:0] st, input logic [7:0] eol, input logic [2:0] par,
			input logic [1:0] chk);
		settle(SETTLE_CYCLES);
		write_reg(REG_PAD_COUNT, {3'd0, pads});
		write_reg(REG_PAD_CHAR, pch);
		write_reg(REG_START_CHAR, st);
		write_reg(REG_EOL_CHAR, eol);
		write_reg(REG_PARITY_MODE, {5'd0, par});
		write_reg(REG_CHECK_TYPE, {6'd0, chk});
	endtask

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	// mostly well-formed packets with random content, the rest stray words
	task automatic run_random(input int target);
		int          sent;
		int unsigned pick;
		int unsigned nd;
		logic        head_has;
		logic        tail_has;
		logic [6:0]  len;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				nd = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
				head_has = 1'($urandom_range(1));
				tail_has = 1'($urandom_range(1));
				len = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
					: 7'(nd + head_has + tail_has);
				if (nd == 0 && $urandom_range(2) == 0) begin
					send_word(7'($urandom_range(127)), 6'($urandom_range(63)), len,
						rand_byte(), head_has, 1'b1, 1'b1);
					sent++;
				end else begin
					send_word(7'($urandom_range(127)), 6'($urandom_range(63)), len,
						rand_byte(), head_has, 1'b1, 1'b0);
					for (int i = 0; i < nd; i++) begin
						if ($urandom_range(49) == 0)
							settle(0);
						send_word(7'($urandom_range(127)), 6'($urandom_range(63)),
							7'($urandom_range(127)), rand_byte(), 1'b1, 1'b0, 1'b0);
					end
					send_word(7'($urandom_range(127)), 6'($urandom_range(63)),
						7'($urandom_range(127)), rand_byte(), tail_has, 1'b0, 1'b1);
					sent += nd + 2;
				end
			end else if (pick < 88) begin
				send_word(7'($urandom_range(127)), 6'($urandom_range(63)),
					7'($urandom_range(127)), rand_byte(), 1'b0, 1'b0, 1'b0);
			end else if (pick < 94) begin
				send_word(7'($urandom_range(127)), 6'($urandom_range(63)),
					7'($urandom_range(127)), rand_byte(), 1'b1, 1'b0, 1'b0);
				sent++;
			end else begin
				send_word(7'($urandom_range(127)), 6'($urandom_range(63)),
					7'($urandom_range(127)), rand_byte(), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'b1);
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: plain packet, empty packet, stray and idle words
		send_word(7'd0, 6'd0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b0);
		send_word(7'd0, 6'd0, 7'd0, 8'hFF, 1'b1, 1'b0, 1'b0);
		send_word(7'd0, 6'd0, 7'd0, 8'h80, 1'b1, 1'b0, 1'b1);
		send_word(7'd127, 6'd63, 7'd127, 8'h00, 1'b0, 1'b1, 1'b1);
		send_word(7'h55, 6'h2A, 7'h55, 8'h55, 1'b0, 1'b0, 1'b0);
		send_word(7'h2A, 6'h15, 7'h2A, 8'hAA, 1'b1, 1'b0, 1'b0);
		send_word(7'h59, 6'd1, 7'd91, 8'h00, 1'b0, 1'b1, 1'b0);
		settle(0);
		send_word(7'd0, 6'd0, 7'd0, 8'h7F, 1'b1, 1'b0, 1'b0);
		send_word(7'd0, 6'd0, 7'd0, 8'h00, 1'b0, 1'b0, 1'b1);

		configure(5'd16, 8'hFF, 8'h00, 8'hFF, PAR_MARK, CHK_SUM12);
		send_word(7'd127, 6'd63, 7'd127, 8'hFF, 1'b1, 1'b1, 1'b1);
		run_random(40);

		configure(5'd31, 8'h55, 8'hFF, 8'h00, PAR_SPACE, CHK_CRC);
		send_word(7'd127, 6'd63, 7'd127, 8'hFF, 1'b1, 1'b1, 1'b1);
		send_word(7'd0, 6'd0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1);
		calm = 1'b1;
		run_random(40);
		calm = 1'b0;

		configure(5'd3, 8'hAA, 8'h01, 8'h0D, PAR_ODD, CHK_UNSET);
		send_word(7'h7F, 6'h3F, 7'h00, 8'hFF, 1'b1, 1'b1, 1'b1);
		run_random(40);

		configure(5'd1, 8'h20, 8'h7E, 8'h0D, PAR_EVEN, CHK_CRC);
		send_word(7'h00, 6'h00, 7'h7F, 8'h00, 1'b1, 1'b1, 1'b1);
		run_random(40);

		configure(5'd0, 8'h00, 8'h01, 8'h0D, PAR_NONE, CHK_SUM6);
		run_random(40);

		for (int ph = 0; ph < 5; ph++) begin
			configure(($urandom_range(5) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(4)),
				rand_byte(), rand_byte(), rand_byte(), 3'($urandom_range(7)),
				2'($urandom_range(3)));
			run_random(40);
		end

		settle(SETTLE_CYCLES);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
